[rtl/core/hsc_pkg.sv]
// Shared types and codes for the Hamming single-error-correcting codec.
package hsc_pkg;

    // Codeword, syndrome and status widths
    localparam int WORD_W = 63;
    localparam int POS_W  = 6;
    localparam int STAT_W = 2;

    // Command codes
    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_FIX = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FIXED = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

    // Control that travels with each word down the pipe
    typedef struct packed {
        logic valid;
        logic cmd;
    } t_ctl;

endpackage

[rtl/core/hsc_scatter.sv]
// Stage 1: mask the input word and, on encode, place data bits at non-power-of-two positions.
module hsc_scatter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hsc_pkg::t_ctl              i_ctl,
    input  logic [hsc_pkg::WORD_W-1:0] i_word,
    input  logic [hsc_pkg::POS_W-1:0]  i_k,
    input  logic [hsc_pkg::POS_W-1:0]  i_n,
    output hsc_pkg::t_ctl              o_ctl,
    output logic [hsc_pkg::WORD_W-1:0] o_cw
);
    import hsc_pkg::*;

    // data index for codeword position p: p-1 minus the powers of two up to p
    function automatic int data_index(input int p);
        int cnt;
        cnt = 0;
        for (int i = 0; i < POS_W; i++) begin
            if ((1 << i) <= p) cnt++;
        end
        return p - 1 - cnt;
    endfunction

    function automatic bit is_pow2(input int p);
        return (p & (p - 1)) == 0;
    endfunction

    t_ctl                r_ctl;
    logic [WORD_W-1:0]   r_cw;
    logic [WORD_W-1:0]   n_cw;
    logic [WORD_W-1:0]   kmask;
    logic [WORD_W-1:0]   nmask;
    logic [WORD_W-1:0]   data;
    logic [WORD_W-1:0]   spread;

    // thermometer masks for data and codeword lengths
    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            kmask[i] = POS_W'(i) < i_k;
            nmask[i] = POS_W'(i) < i_n;
        end
    end

    // fixed wiring of data bits into the codeword, parity slots left zero
    always_comb begin
        data = i_word & kmask;
        for (int p = 1; p <= WORD_W; p++) begin
            if (is_pow2(p)) begin
                spread[p-1] = 1'b0;
            end else begin
                spread[p-1] = data[data_index(p)];
            end
        end
        n_cw = (i_ctl.cmd == CMD_ENC) ? spread : (i_word & nmask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cw <= n_cw;
    end

    assign o_ctl = r_ctl;
    assign o_cw  = r_cw;

endmodule

[rtl/core/hsc_syndrome.sv]
// Stage 2: syndrome as the XOR of the indices of all set positions.
module hsc_syndrome (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hsc_pkg::t_ctl              i_ctl,
    input  logic [hsc_pkg::WORD_W-1:0] i_cw,
    output hsc_pkg::t_ctl              o_ctl,
    output logic [hsc_pkg::WORD_W-1:0] o_cw,
    output logic [hsc_pkg::POS_W-1:0]  o_syn
);
    import hsc_pkg::*;

    t_ctl                r_ctl;
    logic [WORD_W-1:0]   r_cw;
    logic [POS_W-1:0]    r_syn;
    logic [POS_W-1:0]    n_syn;

    // six parity trees over the codeword
    always_comb begin
        n_syn = '0;
        for (int p = 1; p <= WORD_W; p++) begin
            if (i_cw[p-1]) n_syn = n_syn ^ POS_W'(p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cw  <= i_cw;
        r_syn <= n_syn;
    end

    assign o_ctl = r_ctl;
    assign o_cw  = r_cw;
    assign o_syn = r_syn;

endmodule

[rtl/core/hsc_fix.sv]
// Stage 3: insert parity on encode, or flip the named bit and classify on correct.
module hsc_fix (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hsc_pkg::t_ctl              i_ctl,
    input  logic [hsc_pkg::WORD_W-1:0] i_cw,
    input  logic [hsc_pkg::POS_W-1:0]  i_syn,
    input  logic [hsc_pkg::POS_W-1:0]  i_n,
    output logic                       o_valid,
    output logic [hsc_pkg::WORD_W-1:0] o_word,
    output logic [hsc_pkg::POS_W-1:0]  o_epos,
    output logic [hsc_pkg::STAT_W-1:0] o_status
);
    import hsc_pkg::*;

    logic                r_valid;
    logic [WORD_W-1:0]   r_word;
    logic [POS_W-1:0]    r_epos;
    logic [STAT_W-1:0]   r_status;
    logic [WORD_W-1:0]   n_word;
    logic [POS_W-1:0]    n_epos;
    logic [STAT_W-1:0]   n_status;
    logic [WORD_W-1:0]   flip;
    logic [WORD_W-1:0]   par;

    always_comb begin
        // one-hot decode of the syndrome, position p at bit p-1
        for (int p = 1; p <= WORD_W; p++) begin
            flip[p-1] = (i_syn == POS_W'(p));
        end
        // parity bit i lands at position 2^i
        par = '0;
        for (int i = 0; i < POS_W; i++) begin
            par[(1 << i) - 1] = i_syn[i];
        end

        n_word   = i_cw;
        n_epos   = '0;
        n_status = ST_OK;
        if (i_ctl.cmd == CMD_ENC) begin
            n_word = i_cw | par;
        end else begin
            n_epos = i_syn;
            if (i_syn == '0) begin
                n_status = ST_OK;
            end else if (i_syn <= i_n) begin
                n_word   = i_cw ^ flip;
                n_status = ST_FIXED;
            end else begin
                n_status = ST_BAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_epos   <= n_epos;
        r_status <= n_status;
    end

    assign o_valid  = r_valid;
    assign o_word   = r_word;
    assign o_epos   = r_epos;
    assign o_status = r_status;

endmodule

[rtl/core/hamming_sec_codec_unit.sv]
// Top level of the Hamming single-error-correcting codec: config register and 3-stage pipe.
// Pipeline: an accepted word passes the scatter, syndrome and fix stages, each registered,
//   and its result is on the outputs, with o_valid, for exactly one cycle.
// Throughput: one word per cycle; busy is always low and the receiver cannot stall.
// Reset: pipeline valid bits clear; data length returns to 8 bits.
// Config writes are taken every cycle (o_cfg_ready high); write only while the pipe is empty.
module hamming_sec_codec_unit #(
    parameter int CODE_BITS = 63
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cmd,
    input  logic [hsc_pkg::WORD_W-1:0] i_word,
    output logic                       o_valid,
    output logic [hsc_pkg::WORD_W-1:0] o_result_word,
    output logic [hsc_pkg::POS_W-1:0]  o_error_position,
    output logic [hsc_pkg::STAT_W-1:0] o_status,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [hsc_pkg::POS_W-1:0]  i_cfg_data
);
    import hsc_pkg::*;

    // fewest parity bits r with 2^r >= k + r + 1
    function automatic int parity_count(input int k);
        int r;
        r = 1;
        for (int i = 0; i < POS_W; i++) begin
            if ((1 << r) < k + r + 1) r++;
        end
        return r;
    endfunction

    // largest data length whose codeword fits in CODE_BITS
    function automatic int max_data(input int code_bits);
        int best;
        best = 1;
        for (int k = 1; k <= 57; k++) begin
            if (k + parity_count(k) <= code_bits) best = k;
        end
        return best;
    endfunction

    localparam int K_MAX   = max_data(CODE_BITS);
    localparam int K_RESET = (8 > K_MAX) ? K_MAX : 8;
    localparam int N_RESET = K_RESET + parity_count(K_RESET);

    logic [POS_W-1:0] r_k;
    logic [POS_W-1:0] r_n;
    logic [POS_W-1:0] n_k;
    logic [POS_W-1:0] n_n;
    logic             cfg_wr;

    // clamp the written length and derive codeword length
    always_comb begin
        n_k = i_cfg_data;
        if (n_k == '0) n_k = POS_W'(1);
        if (n_k > POS_W'(57)) n_k = POS_W'(57);
        if (n_k > POS_W'(K_MAX)) n_k = POS_W'(K_MAX);
        n_n = n_k + POS_W'(parity_count(int'(n_k)));
    end

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= POS_W'(K_RESET);
            r_n <= POS_W'(N_RESET);
        end else if (cfg_wr) begin
            r_k <= n_k;
            r_n <= n_n;
        end
    end

    // pipeline
    t_ctl              in_ctl;
    t_ctl              s1_ctl;
    t_ctl              s2_ctl;
    logic [WORD_W-1:0] s1_cw;
    logic [WORD_W-1:0] s2_cw;
    logic [POS_W-1:0]  s2_syn;

    assign busy         = 1'b0;
    assign in_ctl.valid = start && !busy;
    assign in_ctl.cmd   = i_cmd;

    hsc_scatter u_scatter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (in_ctl),
        .i_word  (i_word),
        .i_k     (r_k),
        .i_n     (r_n),
        .o_ctl   (s1_ctl),
        .o_cw    (s1_cw)
    );

    hsc_syndrome u_syndrome (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s1_ctl),
        .i_cw    (s1_cw),
        .o_ctl   (s2_ctl),
        .o_cw    (s2_cw),
        .o_syn   (s2_syn)
    );

    hsc_fix u_fix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s2_ctl),
        .i_cw     (s2_cw),
        .i_syn    (s2_syn),
        .i_n      (r_n),
        .o_valid  (o_valid),
        .o_word   (o_result_word),
        .o_epos   (o_error_position),
        .o_status (o_status)
    );

    // a result is only reported for a word that was taken at the input
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 3))
        else $error("result without matching start");

    // any error report comes from a correct command
    a_err_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> ($past(i_cmd, 3) == CMD_FIX))
        else $error("error status on encode");

    // a reported error always carries a nonzero syndrome
    a_err_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FIXED || o_status == ST_BAD)) |->
        (o_error_position != '0))
        else $error("error status with zero syndrome");

    // a corrected position lies inside the codeword
    a_fix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FIXED) |-> (o_error_position <= r_n))
        else $error("corrected position beyond codeword");

endmodule

[tb/sv/tb_top.sv]
// Testbench for the Hamming single-error-correcting codec: random and directed words, self-checking.
module tb_top;
    import hsc_pkg::*;

    // One expected or observed codec output
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;
        logic [STAT_W-1:0] stat;
    } t_codec_out;

    // Expected-output store plus a bit-level model of the codec
    class codec_scoreboard;
        int unsigned  data_len;
        t_codec_out   pending_outs[$];
        int           errors;

        function new();
            data_len = 8;
            errors   = 0;
        endfunction

        function void set_length(logic [POS_W-1:0] v);
            data_len = v;
        endfunction

        // Data bit count after clamping to what fits in the codeword
        function int data_bits();
            int k;
            k = data_len;
            if (k < 1) k = 1;
            if (k > 57) k = 57;
            while (k > 1 && k + parity_bits(k) > WORD_W) k--;
            return k;
        endfunction

        function int parity_bits(int k);
            int r;
            r = 1;
            while ((1 << r) < k + r + 1) r++;
            return r;
        endfunction

        function int code_len();
            return data_bits() + parity_bits(data_bits());
        endfunction

        function int syndrome(logic [WORD_W-1:0] cw, int n);
            int s;
            s = 0;
            for (int p = 1; p <= n; p++)
                if (cw[p-1]) s ^= p;
            return s;
        endfunction

        function t_codec_out predict(logic cmd, logic [WORD_W-1:0] w);
            t_codec_out res;
            int k, r, n, d, syn;
            k   = data_bits();
            r   = parity_bits(k);
            n   = k + r;
            res = '0;
            if (cmd == CMD_ENC) begin
                // scatter data over non-power-of-two positions, then fill parity
                d = 0;
                for (int p = 1; p <= n; p++) begin
                    if ((p & (p - 1)) != 0) begin
                        res.word[p-1] = w[d];
                        d++;
                    end
                end
                syn = syndrome(res.word, n);
                for (int i = 0; i < r; i++)
                    if (syn[i]) res.word[(1 << i) - 1] = 1'b1;
            end else begin
                for (int p = 0; p < n; p++) res.word[p] = w[p];
                syn     = syndrome(res.word, n);
                res.pos = syn[POS_W-1:0];
                if (syn == 0) begin
                    res.stat = ST_OK;
                end else if (syn <= n) begin
                    res.word[syn-1] = ~res.word[syn-1];
                    res.stat = ST_FIXED;
                end else begin
                    res.stat = ST_BAD;
                end
            end
            return res;
        endfunction

        function void note_word(logic cmd, logic [WORD_W-1:0] w);
            pending_outs = {pending_outs, predict(cmd, w)};
        endfunction

        function void check_word(t_codec_out got);
            t_codec_out want;
            if (pending_outs.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result word=%h pos=%0d status=%0d",
                             got.word, got.pos, got.stat);
                return;
            end
            want = pending_outs.pop_front();
            if (got.word !== want.word || got.pos !== want.pos || got.stat !== want.stat) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: exp word=%h pos=%0d status=%0d, got word=%h pos=%0d status=%0d",
                             want.word, want.pos, want.stat, got.word, got.pos, got.stat);
            end
        endfunction

        function int outstanding();
            return pending_outs.size();
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              i_cmd       = 1'b0;
    logic [WORD_W-1:0] i_word      = '0;
    logic              i_cfg_valid = 1'b0;
    logic [POS_W-1:0]  i_cfg_data  = '0;
    logic              busy;
    logic              o_valid;
    logic [WORD_W-1:0] o_result_word;
    logic [POS_W-1:0]  o_error_position;
    logic [STAT_W-1:0] o_status;
    logic              o_cfg_ready;

    codec_scoreboard sb = new();
    int              idle_pct = 0;

    hamming_sec_codec_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_word           (i_word),
        .o_valid          (o_valid),
        .o_result_word    (o_result_word),
        .o_error_position (o_error_position),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // Monitor: config writes, accepted words and results, all on pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_length(i_cfg_data);
            if (start && !busy) sb.note_word(i_cmd, i_word);
            if (o_valid) sb.check_word({o_result_word, o_error_position, o_status});
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        logic [63:0] t;
        t = {$urandom(), $urandom()};
        return t[WORD_W-1:0];
    endfunction

    // Present one word and hold it until taken; start stays high afterwards
    task automatic send_word(logic cmd, logic [WORD_W-1:0] w);
        if (idle_pct > 0) begin
            while ($urandom_range(99) < idle_pct) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start  <= 1'b1;
        i_cmd  <= cmd;
        i_word <= w;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending and wait out every outstanding result plus pipe latency
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_length(logic [POS_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random encodes, real codewords with 0..2 flipped bits, raw words and extremes
    task automatic send_random();
        logic [WORD_W-1:0] cw, hi_mask;
        int                roll, n, flips;
        roll    = $urandom_range(99);
        n       = sb.code_len();
        hi_mask = ~({WORD_W{1'b1}} >> (WORD_W - n));
        if (roll < 35) begin
            send_word(CMD_ENC, rand_word());
        end else if (roll < 80) begin
            cw    = sb.predict(CMD_ENC, rand_word()).word;
            flips = $urandom_range(2);
            for (int i = 0; i < flips; i++) cw[$urandom_range(n - 1)] ^= 1'b1;
            if ($urandom_range(4) == 0) cw |= rand_word() & hi_mask;
            send_word(CMD_FIX, cw);
        end else if (roll < 92) begin
            send_word(CMD_FIX, rand_word());
        end else begin
            send_word(logic'($urandom_range(1)), ($urandom_range(1) != 0) ? '1 : '0);
        end
    endtask

    initial begin
        logic [WORD_W-1:0] good_cw;
        int                lengths[10];
        lengths = '{1, 57, 0, 63, 4, 26, 11, 32, 8, 0};
        lengths[9] = $urandom_range(63);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the reset length of 8 data bits (12-bit codeword)
        send_word(CMD_ENC, '0);
        send_word(CMD_ENC, 63'hFF);
        send_word(CMD_ENC, '1);
        send_word(CMD_ENC, 63'hA5);
        good_cw = sb.predict(CMD_ENC, 63'hA5).word;
        send_word(CMD_FIX, good_cw);
        send_word(CMD_FIX, good_cw ^ 63'h001);
        send_word(CMD_FIX, good_cw ^ 63'h002);
        send_word(CMD_FIX, good_cw ^ 63'h004);
        send_word(CMD_FIX, good_cw ^ 63'h008);
        send_word(CMD_FIX, good_cw ^ 63'h080);
        send_word(CMD_FIX, good_cw ^ 63'h800);
        // junk above the codeword is dropped
        send_word(CMD_FIX, good_cw | (63'h1 << 62));
        // syndromes 13 and 15 point past the 12-bit codeword
        send_word(CMD_FIX, 63'h089);
        send_word(CMD_FIX, 63'h804);
        send_word(CMD_FIX, '1);
        send_word(CMD_FIX, '0);

        // Random phases across lengths, cycling the idle patterns
        foreach (lengths[i]) begin
            drain();
            write_length(lengths[i][POS_W-1:0]);
            case (i % 4)
                0: idle_pct = 0;
                1: idle_pct = 81;
                2: idle_pct = 0;
                default: idle_pct = 10;
            endcase
            repeat (85) send_random();
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
